// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define VTD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, masked while reset is high
`define VTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds across reset
`define VTD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: check across reset failed");

`endif

// ----- src/vtd_pkg.sv -----
// ---------------------------------------------------------------------------
// vtd_pkg
// Shared widths, defaults, stage record and arctangent table for the
// vector direction pipeline.
// ---------------------------------------------------------------------------
package vtd_pkg;

   // Field widths
   localparam int VEC_W   = 32;
   localparam int DIR_W   = 15;
   localparam int ANGLE_W = 32;

   // Datapath: components are prescaled by 2^24 and grow by the CORDIC gain
   localparam int PRESCALE_SHIFT = 24;
   localparam int DATA_W         = 60;

   // Parameter defaults
   localparam int DEF_DIRECTION_STEPS = 128;
   localparam int DEF_FRACTION_BITS   = 8;
   localparam int DEF_CORDIC_STAGES   = 20;

   // Half a turn in binary-turn units
   localparam logic [ANGLE_W-1:0] TURN_HALF = 32'h8000_0000;

   // round(atan(2^-i) / (2*pi) * 2^32)
   localparam logic [ANGLE_W-1:0] ATAN_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // Record carried between rotation stages
   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic [ANGLE_W-1:0]       z;
      logic                     zero;
   } rot_type;

endpackage

// ----- src/vtd_req_if.sv -----
// ---------------------------------------------------------------------------
// vtd_req_if
// Vector request channel: valid/ready with the two vector components.
// ---------------------------------------------------------------------------
interface vtd_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [vtd_pkg::VEC_W-1:0]  vec_x;
   logic signed [vtd_pkg::VEC_W-1:0]  vec_y;

   modport source (output valid, output vec_x, output vec_y, input ready);
   modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

// ----- src/vtd_rsp_if.sv -----
// ---------------------------------------------------------------------------
// vtd_rsp_if
// Direction response channel: valid/ready with the direction code.
// ---------------------------------------------------------------------------
interface vtd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vtd_pkg::DIR_W-1:0]   direction;

   modport source (output valid, output direction, input ready);
   modport sink   (input valid, input direction, output ready);
endinterface

// ----- src/vtd_cordic_stage.sv -----
// ---------------------------------------------------------------------------
// vtd_cordic_stage
// One registered CORDIC vectoring micro-rotation with its own valid bit.
// ---------------------------------------------------------------------------
module vtd_cordic_stage #(
   parameter int SHIFT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              in_valid,
   input  vtd_pkg::rot_type  in_data,
   output logic              out_valid,
   output vtd_pkg::rot_type  out_data
);
   import vtd_pkg::*;

   logic    valid_ff;
   rot_type data_ff;
   rot_type data_in;

   logic signed [DATA_W-1:0] x_cur;
   logic signed [DATA_W-1:0] y_cur;
   logic signed [DATA_W-1:0] x_shr;
   logic signed [DATA_W-1:0] y_shr;

   // Rotate toward the x axis: clockwise when y is non-negative
   always_comb begin
      x_cur        = in_data.x;
      y_cur        = in_data.y;
      x_shr        = x_cur >>> SHIFT;
      y_shr        = y_cur >>> SHIFT;
      data_in.zero = in_data.zero;
      if (!y_cur[DATA_W-1]) begin
         data_in.x = x_cur + y_shr;
         data_in.y = y_cur - x_shr;
         data_in.z = in_data.z + ATAN_TURN[SHIFT];
      end else begin
         data_in.x = x_cur - y_shr;
         data_in.y = y_cur + x_shr;
         data_in.z = in_data.z - ATAN_TURN[SHIFT];
      end
   end

   // Hold while the next stage is full and stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- src/vector_to_direction.sv -----
// ---------------------------------------------------------------------------
// vector_to_direction
// Direction of a Q16.16 vector in fractional direction steps, by CORDIC.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one vector (vec_x, vec_y, signed Q16.16) per beat; rsp
//   returns one direction per beat, in units of 1/DIRECTION_STEPS of a turn
//   with FRACTION_BITS fraction bits, counter-clockwise from +x, folded into
//   [0, DIRECTION_STEPS). A zero vector gives 0.
//   Request beat to response valid passes one prepare stage, one register
//   per micro-rotation, one multiply stage and one output register.
//   Throughput: one vector per cycle while rsp does not stall, set by the
//   fully pipelined rotation chain.
//   Each stage loads whenever it is empty or the stage after it moves, so
//   when rsp stalls the pipeline keeps taking vectors until every stage is
//   full; only then does req.ready fall. Nothing is dropped or repeated.
//   Reset clears all valid bits; req.ready is high in the cycle after reset.
// ---------------------------------------------------------------------------
module vector_to_direction #(
   parameter int DIRECTION_STEPS = vtd_pkg::DEF_DIRECTION_STEPS,
   parameter int FRACTION_BITS   = vtd_pkg::DEF_FRACTION_BITS,
   parameter int CORDIC_STAGES   = vtd_pkg::DEF_CORDIC_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   vtd_req_if.sink     req,
   vtd_rsp_if.source   rsp
);
   import vtd_pkg::*;

   localparam int SPAN_W = $clog2(DIRECTION_STEPS + 1) + FRACTION_BITS;
   localparam int PROD_W = ANGLE_W + SPAN_W;
   localparam int RES_W  = PROD_W + 1 - ANGLE_W;
   localparam logic [SPAN_W-1:0] SPAN = SPAN_W'(DIRECTION_STEPS) << FRACTION_BITS;
   localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << (ANGLE_W - 1);

   // Stage k = 0 is prepare, 1..CORDIC_STAGES are rotations
   logic [CORDIC_STAGES:0]     stage_valid;
   rot_type                    stage_data [CORDIC_STAGES+1];
   logic [CORDIC_STAGES+1:0]   stage_load;

   logic                       mult_load;
   logic                       mult_valid_ff;
   logic [PROD_W-1:0]          mult_prod_ff;
   logic                       mult_zero_ff;

   logic                       out_load;
   logic                       rsp_valid_ff;
   logic [DIR_W-1:0]           rsp_direction_ff;

   logic                       prep_valid_ff;
   rot_type                    prep_data_ff;
   rot_type                    prep_data_in;

   logic signed [VEC_W:0]      vx_ext;
   logic signed [VEC_W:0]      vy_ext;
   logic signed [VEC_W:0]      vx_fold;
   logic signed [VEC_W:0]      vy_fold;

   logic [PROD_W:0]            round_sum;
   logic [RES_W-1:0]           res_raw;
   logic [RES_W-1:0]           res_fold;

   // Load chain: a stage takes new data when empty or when its item moves on
   assign out_load  = !rsp_valid_ff || rsp.ready;
   assign mult_load = !mult_valid_ff || out_load;
   assign stage_load[CORDIC_STAGES+1] = mult_load;

   for (genvar k = 0; k <= CORDIC_STAGES; k++) begin : g_load
      assign stage_load[k] = !stage_valid[k] || stage_load[k+1];
   end

   assign req.ready = stage_load[0];

   // Prepare: fold the left half-plane by half a turn, prescale by 2^24
   always_comb begin
      vx_ext = {req.vec_x[VEC_W-1], req.vec_x};
      vy_ext = {req.vec_y[VEC_W-1], req.vec_y};
      if (req.vec_x[VEC_W-1]) begin
         vx_fold        = -vx_ext;
         vy_fold        = -vy_ext;
         prep_data_in.z = TURN_HALF;
      end else begin
         vx_fold        = vx_ext;
         vy_fold        = vy_ext;
         prep_data_in.z = '0;
      end
      prep_data_in.x    = DATA_W'(vx_fold) <<< PRESCALE_SHIFT;
      prep_data_in.y    = DATA_W'(vy_fold) <<< PRESCALE_SHIFT;
      prep_data_in.zero = (req.vec_x == '0) && (req.vec_y == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (stage_load[0]) begin
         prep_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         prep_data_ff <= prep_data_in;
      end
   end

   assign stage_valid[0] = prep_valid_ff;
   assign stage_data[0]  = prep_data_ff;

   // Rotation chain, one micro-rotation per register stage
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      vtd_cordic_stage #(
         .SHIFT (i)
      ) u_vtd_cordic_stage (
         .clock     (clock),
         .reset     (reset),
         .load      (stage_load[i+1]),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   // Scale the binary turn to direction steps
   always_ff @(posedge clock) begin
      if (reset) begin
         mult_valid_ff <= 1'b0;
      end else if (mult_load) begin
         mult_valid_ff <= stage_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (mult_load) begin
         mult_prod_ff <= PROD_W'(stage_data[CORDIC_STAGES].z) * PROD_W'(SPAN);
         mult_zero_ff <= stage_data[CORDIC_STAGES].zero;
      end
   end

   // Round half up, wrap a full turn to zero
   always_comb begin
      round_sum = {1'b0, mult_prod_ff} + ROUND_HALF;
      res_raw   = round_sum[PROD_W:ANGLE_W];
      if (res_raw >= RES_W'(SPAN)) begin
         res_fold = res_raw - RES_W'(SPAN);
      end else begin
         res_fold = res_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= mult_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_direction_ff <= mult_zero_ff ? '0 : DIR_W'(res_fold);
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.direction = rsp_direction_ff;

endmodule

// ----- src/vtd_checker.sv -----
// ---------------------------------------------------------------------------
// vtd_checker
// Port-level checks on the vector direction pipeline, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vtd_checker #(
   parameter int DIRECTION_STEPS = vtd_pkg::DEF_DIRECTION_STEPS,
   parameter int FRACTION_BITS   = vtd_pkg::DEF_FRACTION_BITS
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [vtd_pkg::DIR_W-1:0]  rsp_direction
);
   import vtd_pkg::*;

   localparam logic [31:0] SPAN_LIMIT = 32'(DIRECTION_STEPS) << FRACTION_BITS;

   logic rsp_stall;
   logic req_seen;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_seen  = req_valid || !req_valid;

   // A stalled response beat stays and holds its payload
   `VTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `VTD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_direction))

   // Direction always lies inside one turn
   `VTD_ASSERT_IMPL(a_dir_range, clock, reset, rsp_valid, 32'(rsp_direction) < SPAN_LIMIT)

   // An empty output register means the pipeline can take a vector
   `VTD_ASSERT_IMPL(a_ready_when_empty, clock, reset, req_seen && !rsp_valid, req_ready)

   // Reset empties the pipeline
   `VTD_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind vector_to_direction vtd_checker #(
   .DIRECTION_STEPS (DIRECTION_STEPS),
   .FRACTION_BITS   (FRACTION_BITS)
) u_vtd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_direction (rsp.direction)
);

// ----- tb/sv/vtd_direction_checker.sv -----
// ---------------------------------------------------------------------------
// vtd_direction_checker
// Watches the vector and direction channels, works out the direction of
// every accepted vector and compares it with the returned beats in order.
// ---------------------------------------------------------------------------
module vtd_direction_checker (
   input  logic  clock,
   input  logic  reset,
   vtd_req_if    req,
   vtd_rsp_if    rsp,
   output int    fail_count,
   output int    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          STEPS      = vtd_pkg::DEF_DIRECTION_STEPS;
   localparam int          FRAC       = vtd_pkg::DEF_FRACTION_BITS;
   localparam int          STAGES     = vtd_pkg::DEF_CORDIC_STAGES;
   localparam longint      PRESCALE   = longint'(1) << 24;
   localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

   // Micro-rotation angles in binary turns: round(atan(2^-i) / 2pi * 2^32)
   localparam logic [31:0] STAGE_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct {
      logic signed [vtd_pkg::VEC_W-1:0] vec_x;
      logic signed [vtd_pkg::VEC_W-1:0] vec_y;
      logic [vtd_pkg::DIR_W-1:0]        direction;
   } heading_type;

   heading_type headings_due [$];
   heading_type oldest;

   // Vectoring CORDIC on a 64-bit datapath, angle kept as a wrapping turn
   function automatic logic [vtd_pkg::DIR_W-1:0] heading_of(
      input logic signed [vtd_pkg::VEC_W-1:0] vx,
      input logic signed [vtd_pkg::VEC_W-1:0] vy
   );
      longint          x;
      longint          y;
      longint          xs;
      longint          ys;
      logic [31:0]     turn;
      longint unsigned span;
      longint unsigned scaled;
      x    = vx;
      y    = vy;
      turn = '0;
      if (x == 0 && y == 0) return '0;
      // Left half-plane: rotate by half a turn first
      if (x < 0) begin
         x    = -x;
         y    = -y;
         turn = HALF_TURN;
      end
      x = x * PRESCALE;
      y = y * PRESCALE;
      for (int i = 0; i < STAGES && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x    = x + ys;
            y    = y - xs;
            turn = turn + STAGE_TURN[i];
         end else begin
            x    = x - ys;
            y    = y + xs;
            turn = turn - STAGE_TURN[i];
         end
      end
      // Scale to steps, round half up, fold a full turn back to zero
      span   = longint'(STEPS) << FRAC;
      scaled = (longint'(turn) * span + 64'h8000_0000) >> 32;
      if (scaled >= span) scaled = scaled - span;
      return scaled[vtd_pkg::DIR_W-1:0];
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Queue a prediction per vector beat, retire one per direction beat
   always @(posedge clock) begin
      if (reset) begin
         headings_due.delete();
         pending <= 0;
      end else begin
         if (req.valid && req.ready)
            headings_due.push_back('{req.vec_x, req.vec_y,
                                     heading_of(req.vec_x, req.vec_y)});
         if (rsp.valid && rsp.ready) begin
            if (headings_due.size() == 0) begin
               $error("direction beat %0d with no vector outstanding", rsp.direction);
               fail_count++;
            end else begin
               oldest = headings_due.pop_front();
               if (rsp.direction !== oldest.direction) begin
                  $error("direction: expected %0d, actual %0d (vec_x %0d, vec_y %0d)",
                         oldest.direction, rsp.direction, oldest.vec_x, oldest.vec_y);
                  fail_count++;
               end
            end
         end
         pending <= headings_due.size();
      end
   end

endmodule

// ----- tb/sv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Drives vectors into vector_to_direction: a directed set of axes, extremes
// and wrap-around corners, then random vectors of mixed magnitude, with
// bursts of idling on both channels. Checking is left to the checker.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VMIN = 32'sh8000_0000;
   localparam int                 CORNER_COUNT = 23;
   localparam int                 RANDOM_BLOCKS = 9;
   localparam int                 BLOCK_VECTORS = 48;

   // Zero vector, axes, negative x axis, extremes, and y just below zero
   // so that the angle sits just short of a full turn
   localparam logic signed [31:0] CORNER_X [CORNER_COUNT] = '{
      0, 1, 0, -1, 0, -65536, VMAX, VMIN, 0, 0, VMAX, VMIN,
      VMIN, VMAX, VMAX, 65536, 1, -1, -1, 1, VMIN, VMIN, -1
   };
   localparam logic signed [31:0] CORNER_Y [CORNER_COUNT] = '{
      0, 0, 1, 0, -1, 0, 0, 0, VMAX, VMIN, VMAX, VMIN,
      VMAX, VMIN, -1, -1, -1, 1, -1, 1, -1, 1, VMIN
   };

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   sender_idles;
   bit   receiver_idles;

   vtd_req_if req_chan ();
   vtd_rsp_if rsp_chan ();

   vector_to_direction u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   vtd_direction_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[vector_to_direction] ERROR");
      $finish;
   end

   // Offer one vector beat, after an idle burst now and then
   task automatic send_vector(input logic signed [31:0] vx, input logic signed [31:0] vy);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.vec_x <= vx;
      req_chan.vec_y <= vy;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Hold the request side quiet until the pipeline has emptied
   task automatic drain(input int limit);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < limit && pending != 0; n++) @(posedge clock);
   endtask

   // Random component: full width, bounded magnitude, tiny, or zero
   function automatic logic signed [31:0] component(input int kind, input int bits);
      unique case (kind)
         0:       return $urandom;
         1:       return $signed($urandom) >>> (31 - bits);
         2:       return $signed($urandom_range(0, 6)) - 3;
         default: return '0;
      endcase
   endfunction

   task automatic send_random_vector();
      int                   shape;
      int                   bits;
      logic signed [31:0]   vx;
      logic signed [31:0]   vy;
      shape = $urandom_range(0, 9);
      bits  = $urandom_range(0, 31);
      unique case (shape)
         0, 1, 2: begin
            vx = component(0, bits);
            vy = component(0, bits);
         end
         3, 4, 5: begin
            vx = component(1, bits);
            vy = component(1, bits);
         end
         6: begin
            vx = component(1, bits);
            vy = component(1, $urandom_range(0, 31));
         end
         7: begin
            vx = component($urandom_range(0, 1) ? 3 : 0, bits);
            vy = (vx == 0) ? component(0, bits) : component(3, bits);
         end
         8: begin
            vx = component(1, bits);
            vy = component(2, bits);
            if ($urandom_range(0, 1)) {vx, vy} = {vy, vx};
         end
         default: begin
            vx = component(1, bits);
            vy = $urandom_range(0, 1) ? vx : -vx;
         end
      endcase
      send_vector(vx, vy);
   endtask

   // Response side: stall in bursts while allowed, otherwise hold ready
   initial begin
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (receiver_idles && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin
      sender_idles   = 1'b0;
      receiver_idles = 1'b1;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.vec_x <= '0;
      req_chan.vec_y <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners
      for (int k = 0; k < CORNER_COUNT; k++) send_vector(CORNER_X[k], CORNER_Y[k]);

      // Random blocks, idling chosen per block, quiet on the last one
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         if (blk == RANDOM_BLOCKS - 1) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end else begin
            sender_idles   = $urandom_range(0, 2) != 0;
            receiver_idles = $urandom_range(0, 2) != 0;
         end
         if (blk == 3) drain(5000);
         for (int k = 0; k < BLOCK_VECTORS; k++) send_random_vector();
      end

      // Wait out the pipeline, then give the verdict
      drain(5000);
      repeat (30) @(posedge clock);
      if (pending != 0) $error("%0d direction beats never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("[vector_to_direction] OK");
      end else begin
         $display("[vector_to_direction] ERROR");
      end
      $finish;
   end

endmodule
